// File: rtl/core/mmt_pkg.sv
// Shared codes and single-precision rounding helpers for the matrix multiply block.
package mmt_pkg;

    localparam int DIM_W = 5;
    localparam int LIM_W = 10;

    localparam logic [2:0] OP_WR_A    = 3'd0;
    localparam logic [2:0] OP_WR_B    = 3'd1;
    localparam logic [2:0] OP_WR_OUT  = 3'd2;
    localparam logic [2:0] OP_COMPUTE = 3'd3;
    localparam logic [2:0] OP_RD_OUT  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [2:0] CFG_A_ROWS  = 3'd0;
    localparam logic [2:0] CFG_A_COLS  = 3'd1;
    localparam logic [2:0] CFG_B_ROWS  = 3'd2;
    localparam logic [2:0] CFG_B_COLS  = 3'd3;
    localparam logic [2:0] CFG_TRANS_A = 3'd4;
    localparam logic [2:0] CFG_TRANS_B = 3'd5;
    localparam logic [2:0] CFG_CLEAR   = 3'd6;

    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic found;
        n = 5'd24;
        found = 1'b0;
        for (int b = 23; b >= 0; b--) begin
            if (!found && v[b]) begin
                n = 5'(23 - b);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic found;
        n = 5'd27;
        found = 1'b0;
        for (int b = 26; b >= 0; b--) begin
            if (!found && v[b]) begin
                n = 5'(26 - b);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Right shift that folds every bit shifted out into bit zero.
    function automatic logic [26:0] shr_sticky(input logic [26:0] m, input logic [4:0] sh);
        logic [26:0] r;
        logic [26:0] mask;
        r = m >> sh;
        mask = ~(27'h7FF_FFFF << sh);
        return r | {26'b0, |(m & mask)};
    endfunction

    // m holds hidden bit at 26, fraction at 25:3, then guard, round and sticky.
    function automatic logic [31:0] round_pack(input logic s, input logic signed [9:0] e,
                                               input logic [26:0] m);
        logic [26:0] mm;
        logic [7:0] ef;
        logic [9:0] sh;
        logic [4:0] sh5;
        logic inc;
        logic [31:0] res;
        mm = m;
        ef = e[7:0];
        sh = 10'(10'sd1 - e);
        sh5 = (sh > 10'd31) ? 5'd31 : sh[4:0];
        if (e < 10'sd1) begin
            mm = shr_sticky(m, sh5);
            ef = 8'd0;
        end
        inc = mm[2] & (mm[3] | mm[1] | mm[0]);
        res = {s, ef, mm[25:3]} + {31'b0, inc};
        if (e >= 10'sd255) begin
            res = {s, 8'hFF, 23'b0};
        end
        return res;
    endfunction

endpackage

// File: rtl/core/mmt_fpu.sv
// Multi-cycle fp32 unit: rounded product a*b, then rounded sum acc+product.
module mmt_fpu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_acc,
    output logic        o_done,
    output logic [31:0] o_result
);
    import mmt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_ADD1, S_ADD2, S_ADD3
    } t_fstate;

    t_fstate r_state;
    logic        r_done;
    logic [31:0] r_a, r_b, r_x, r_y, r_res;
    logic [23:0] r_ma, r_mb;
    logic [47:0] r_p;
    logic signed [9:0] r_pe;
    logic        r_ps, r_spec;
    logic [31:0] r_spec_val;
    logic [26:0] r_ml, r_ms;
    logic [27:0] r_sum;
    logic [7:0]  r_el;
    logic        r_sl, r_sub;

    // Multiplier input stage.
    logic [23:0] n_ma, n_mb;
    logic signed [9:0] n_pe;
    logic        n_spec;
    logic [31:0] n_spec_val;
    logic [31:0] w_prod;

    always_comb begin
        logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s;
        logic [23:0] ra, rb;
        logic [4:0] lza, lzb;
        logic signed [9:0] ea, eb;
        s = r_a[31] ^ r_b[31];
        a_nan  = (&r_a[30:23]) && (|r_a[22:0]);
        b_nan  = (&r_b[30:23]) && (|r_b[22:0]);
        a_inf  = (&r_a[30:23]) && !(|r_a[22:0]);
        b_inf  = (&r_b[30:23]) && !(|r_b[22:0]);
        a_zero = (r_a[30:0] == 31'b0);
        b_zero = (r_b[30:0] == 31'b0);
        ra = {r_a[30:23] != 8'd0, r_a[22:0]};
        rb = {r_b[30:23] != 8'd0, r_b[22:0]};
        lza = lzc24(ra);
        lzb = lzc24(rb);
        n_ma = ra << lza;
        n_mb = rb << lzb;
        ea = (r_a[30:23] == 8'd0) ? 10'sd1 : $signed({2'b0, r_a[30:23]});
        eb = (r_b[30:23] == 8'd0) ? 10'sd1 : $signed({2'b0, r_b[30:23]});
        n_pe = ea - $signed({5'b0, lza}) + eb - $signed({5'b0, lzb}) - 10'sd127;
        n_spec = 1'b1;
        if (a_nan) begin
            n_spec_val = r_a | FP_QUIET_BIT;
        end else if (b_nan) begin
            n_spec_val = r_b | FP_QUIET_BIT;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            n_spec_val = FP_DEFAULT_NAN;
        end else if (a_inf || b_inf) begin
            n_spec_val = {s, 8'hFF, 23'b0};
        end else if (a_zero || b_zero) begin
            n_spec_val = {s, 31'b0};
        end else begin
            n_spec_val = 32'b0;
            n_spec = 1'b0;
        end
    end

    always_comb begin
        if (r_p[47]) begin
            w_prod = round_pack(r_ps, r_pe + 10'sd1, {r_p[47:22], |r_p[21:0]});
        end else begin
            w_prod = round_pack(r_ps, r_pe, {r_p[46:21], |r_p[20:0]});
        end
        if (r_spec) begin
            w_prod = r_spec_val;
        end
    end

    // Adder alignment stage.
    logic [26:0] n_ml, n_ms;
    logic [7:0]  n_el;
    logic        n_sl, n_sub, n_aspec;
    logic [31:0] n_aspec_val;

    always_comb begin
        logic x_nan, y_nan, x_inf, y_inf, swap;
        logic [31:0] lg, sm;
        logic [7:0] el, es, d;
        x_nan = (&r_x[30:23]) && (|r_x[22:0]);
        y_nan = (&r_y[30:23]) && (|r_y[22:0]);
        x_inf = (&r_x[30:23]) && !(|r_x[22:0]);
        y_inf = (&r_y[30:23]) && !(|r_y[22:0]);
        swap = r_y[30:0] > r_x[30:0];
        lg = swap ? r_y : r_x;
        sm = swap ? r_x : r_y;
        el = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
        es = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
        d = el - es;
        n_el = el;
        n_sl = lg[31];
        n_sub = lg[31] ^ sm[31];
        n_ml = {lg[30:23] != 8'd0, lg[22:0], 3'b0};
        n_ms = shr_sticky({sm[30:23] != 8'd0, sm[22:0], 3'b0},
                          (d > 8'd31) ? 5'd31 : d[4:0]);
        n_aspec = 1'b1;
        if (x_nan) begin
            n_aspec_val = r_x | FP_QUIET_BIT;
        end else if (y_nan) begin
            n_aspec_val = r_y | FP_QUIET_BIT;
        end else if (x_inf && y_inf && (r_x[31] != r_y[31])) begin
            n_aspec_val = FP_DEFAULT_NAN;
        end else if (x_inf) begin
            n_aspec_val = r_x;
        end else if (y_inf) begin
            n_aspec_val = r_y;
        end else if ((r_x[30:0] == 31'b0) && (r_y[30:0] == 31'b0)) begin
            n_aspec_val = {r_x[31] & r_y[31], 31'b0};
        end else begin
            n_aspec_val = 32'b0;
            n_aspec = 1'b0;
        end
    end

    logic [31:0] w_sum_res;

    always_comb begin
        logic [4:0] lz;
        logic [26:0] m;
        lz = lzc27(r_sum[26:0]);
        m = r_sum[26:0] << lz;
        if (r_sum[27]) begin
            w_sum_res = round_pack(r_sl, $signed({2'b0, r_el}) + 10'sd1,
                                   {r_sum[27:2], r_sum[1] | r_sum[0]});
        end else begin
            w_sum_res = round_pack(r_sl, $signed({2'b0, r_el}) - $signed({5'b0, lz}), m);
        end
        if (r_sum == 28'b0) begin
            w_sum_res = 32'b0;
        end
        if (r_spec) begin
            w_sum_res = r_spec_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_a <= i_a;
                        r_b <= i_b;
                        r_x <= i_acc;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_ma <= n_ma;
                    r_mb <= n_mb;
                    r_pe <= n_pe;
                    r_ps <= r_a[31] ^ r_b[31];
                    r_spec <= n_spec;
                    r_spec_val <= n_spec_val;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p <= r_ma * r_mb;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_y <= w_prod;
                    r_state <= S_ADD1;
                end
                S_ADD1: begin
                    r_ml <= n_ml;
                    r_ms <= n_ms;
                    r_el <= n_el;
                    r_sl <= n_sl;
                    r_sub <= n_sub;
                    r_spec <= n_aspec;
                    r_spec_val <= n_aspec_val;
                    r_state <= S_ADD2;
                end
                S_ADD2: begin
                    r_sum <= r_sub ? ({1'b0, r_ml} - {1'b0, r_ms})
                                   : ({1'b0, r_ml} + {1'b0, r_ms});
                    r_state <= S_ADD3;
                end
                S_ADD3: begin
                    r_res <= w_sum_res;
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_result = r_res;

endmodule

// File: rtl/core/matrix_multiply_transpose.sv
// Top level: element stores, command sequencer and result stage of the fp32 matrix multiply.
// Each beat carries one command: write an element of A, B or the output, read an output
// element, or run a compute, and returns exactly one result beat. Element writes and unused
// opcodes finish in the execute state, in-range reads in the read-wait state after it. A
// compute walks the output row by row; each output element costs one store read and one
// write-back plus, for each inner step, the A and B store read and wait states and the
// seven-step multiply-then-add unit. One command is in flight at a time, and a finished
// result waits in a two-deep output stage so the next command can be taken meanwhile.
// The stores have no reset; reading an element that was never written returns garbage.
module matrix_multiply_transpose #(
    parameter int MAX_DIM = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // element_address[7:0], element_value[39:8]
    input  logic [2:0]  i_s_axis_tuser,   // opcode[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // read_value[31:0]
    output logic [1:0]  o_m_axis_tuser,   // status[1:0]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_wdata
);
    import mmt_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = $clog2(DEPTH);
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'((MAX_DIM > 31) ? 31 : MAX_DIM);

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_RDWAIT, ST_OREAD, ST_OWAIT, ST_ABREAD, ST_ABWAIT,
        ST_FPU, ST_OWRITE
    } t_state;

    t_state r_state;
    logic [DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic r_trans_a, r_trans_b, r_clear;
    logic [2:0]  r_op;
    logic [7:0]  r_addr;
    logic [31:0] r_val, r_acc;
    logic [DIM_W-1:0] r_i, r_j, r_k;
    logic        r_res_valid, r_m_valid;
    logic [1:0]  r_res_status, r_m_status;
    logic [31:0] r_res_value, r_m_value;

    logic [31:0] r_a_mem [DEPTH];
    logic [31:0] r_b_mem [DEPTH];
    logic [31:0] r_o_mem [DEPTH];
    logic [31:0] r_a_rdata, r_b_rdata, r_o_rdata;

    logic [DIM_W-1:0] w_ar, w_ac, w_br, w_bc, w_inner_a, w_inner_b, w_orows, w_ocols;
    logic [LIM_W-1:0] w_lim_a, w_lim_b, w_lim_o, w_oidx, w_aidx, w_bidx;
    logic w_accept, w_fpu_start, w_fpu_done, w_res_load;
    logic [31:0] w_fpu_result;
    logic w_a_we, w_b_we, w_o_we;
    logic [AW-1:0] w_waddr, w_a_raddr, w_b_raddr, w_o_raddr;
    logic [31:0] w_wdata;

    assign w_ar = (r_a_rows > DIM_CAP) ? DIM_CAP : r_a_rows;
    assign w_ac = (r_a_cols > DIM_CAP) ? DIM_CAP : r_a_cols;
    assign w_br = (r_b_rows > DIM_CAP) ? DIM_CAP : r_b_rows;
    assign w_bc = (r_b_cols > DIM_CAP) ? DIM_CAP : r_b_cols;
    assign w_inner_a = r_trans_a ? w_ar : w_ac;
    assign w_inner_b = r_trans_b ? w_bc : w_br;
    assign w_orows = r_trans_a ? w_ac : w_ar;
    assign w_ocols = r_trans_b ? w_br : w_bc;
    assign w_lim_a = LIM_W'(w_ar) * LIM_W'(w_ac);
    assign w_lim_b = LIM_W'(w_br) * LIM_W'(w_bc);
    assign w_lim_o = LIM_W'(w_orows) * LIM_W'(w_ocols);
    assign w_oidx = LIM_W'(r_i) * LIM_W'(w_ocols) + LIM_W'(r_j);
    assign w_aidx = r_trans_a ? (LIM_W'(r_k) * LIM_W'(w_ac) + LIM_W'(r_i))
                              : (LIM_W'(r_i) * LIM_W'(w_ac) + LIM_W'(r_k));
    assign w_bidx = r_trans_b ? (LIM_W'(r_j) * LIM_W'(w_bc) + LIM_W'(r_k))
                              : (LIM_W'(r_k) * LIM_W'(w_bc) + LIM_W'(r_j));

    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_res_valid;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fpu_start = (r_state == ST_ABWAIT);

    // Store port selection for the current step.
    always_comb begin
        w_a_we = 1'b0;
        w_b_we = 1'b0;
        w_o_we = 1'b0;
        w_waddr = AW'(r_addr);
        w_wdata = r_val;
        w_a_raddr = AW'(w_aidx);
        w_b_raddr = AW'(w_bidx);
        w_o_raddr = AW'(w_oidx);
        if (r_state == ST_EXEC) begin
            w_a_we = (r_op == OP_WR_A) && (LIM_W'(r_addr) < w_lim_a);
            w_b_we = (r_op == OP_WR_B) && (LIM_W'(r_addr) < w_lim_b);
            w_o_we = (r_op == OP_WR_OUT) && (LIM_W'(r_addr) < w_lim_o);
            w_o_raddr = AW'(r_addr);
        end else if (r_state == ST_OWRITE) begin
            w_o_we = 1'b1;
            w_waddr = AW'(w_oidx);
            w_wdata = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            r_a_mem[w_waddr] <= w_wdata;
        end
        if (w_b_we) begin
            r_b_mem[w_waddr] <= w_wdata;
        end
        if (w_o_we) begin
            r_o_mem[w_waddr] <= w_wdata;
        end
        r_a_rdata <= r_a_mem[w_a_raddr];
        r_b_rdata <= r_b_mem[w_b_raddr];
        r_o_rdata <= r_o_mem[w_o_raddr];
    end

    mmt_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_fpu_start),
        .i_a      (r_a_rdata),
        .i_b      (r_b_rdata),
        .i_acc    (r_acc),
        .o_done   (w_fpu_done),
        .o_result (w_fpu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= DIM_W'(1);
            r_a_cols <= DIM_W'(1);
            r_b_rows <= DIM_W'(1);
            r_b_cols <= DIM_W'(1);
            r_trans_a <= 1'b0;
            r_trans_b <= 1'b0;
            r_clear <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_A_ROWS:  r_a_rows <= i_cfg_wdata;
                CFG_A_COLS:  r_a_cols <= i_cfg_wdata;
                CFG_B_ROWS:  r_b_rows <= i_cfg_wdata;
                CFG_B_COLS:  r_b_cols <= i_cfg_wdata;
                CFG_TRANS_A: r_trans_a <= i_cfg_wdata[0];
                CFG_TRANS_B: r_trans_b <= i_cfg_wdata[0];
                CFG_CLEAR:   r_clear <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_res_load = ((r_state == ST_EXEC) && (r_op != OP_COMPUTE)
                         && !((r_op == OP_RD_OUT) && (LIM_W'(r_addr) < w_lim_o)))
                     || ((r_state == ST_EXEC) && (r_op == OP_COMPUTE)
                         && ((w_inner_a != w_inner_b) || (w_lim_o == LIM_W'(0))))
                     || (r_state == ST_RDWAIT)
                     || ((r_state == ST_OWRITE) && (r_j == w_ocols - DIM_W'(1))
                         && (r_i == w_orows - DIM_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_res_valid <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_res_valid && (!r_m_valid || i_m_axis_tready)) begin
                r_m_valid <= 1'b1;
                r_m_status <= r_res_status;
                r_m_value <= r_res_value;
                r_res_valid <= 1'b0;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_res_load) begin
                r_res_valid <= 1'b1;
                r_res_status <= ST_OK;
                r_res_value <= 32'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op <= i_s_axis_tuser;
                        r_addr <= i_s_axis_tdata[7:0];
                        r_val <= i_s_axis_tdata[39:8];
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_IDLE;
                    case (r_op)
                        OP_WR_A: begin
                            if (LIM_W'(r_addr) >= w_lim_a) r_res_status <= ST_RANGE;
                        end
                        OP_WR_B: begin
                            if (LIM_W'(r_addr) >= w_lim_b) r_res_status <= ST_RANGE;
                        end
                        OP_WR_OUT: begin
                            if (LIM_W'(r_addr) >= w_lim_o) r_res_status <= ST_RANGE;
                        end
                        OP_RD_OUT: begin
                            if (LIM_W'(r_addr) >= w_lim_o) begin
                                r_res_status <= ST_RANGE;
                            end else begin
                                r_state <= ST_RDWAIT;
                            end
                        end
                        OP_COMPUTE: begin
                            if (w_inner_a != w_inner_b) begin
                                r_res_status <= ST_MISMATCH;
                            end else if (w_lim_o != LIM_W'(0)) begin
                                r_i <= '0;
                                r_j <= '0;
                                r_state <= ST_OREAD;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_RDWAIT: begin
                    r_res_value <= r_o_rdata;
                    r_state <= ST_IDLE;
                end
                ST_OREAD: r_state <= ST_OWAIT;
                ST_OWAIT: begin
                    // Clearing first is the same as starting each sum from zero.
                    r_acc <= r_clear ? 32'b0 : r_o_rdata;
                    r_k <= '0;
                    r_state <= (w_inner_a == DIM_W'(0)) ? ST_OWRITE : ST_ABREAD;
                end
                ST_ABREAD: r_state <= ST_ABWAIT;
                ST_ABWAIT: r_state <= ST_FPU;
                ST_FPU: begin
                    if (w_fpu_done) begin
                        r_acc <= w_fpu_result;
                        if (r_k == w_inner_a - DIM_W'(1)) begin
                            r_state <= ST_OWRITE;
                        end else begin
                            r_k <= r_k + DIM_W'(1);
                            r_state <= ST_ABREAD;
                        end
                    end
                end
                ST_OWRITE: begin
                    r_state <= ST_OREAD;
                    if (r_j == w_ocols - DIM_W'(1)) begin
                        r_j <= '0;
                        if (r_i == w_orows - DIM_W'(1)) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_i <= r_i + DIM_W'(1);
                        end
                    end else begin
                        r_j <= r_j + DIM_W'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata = r_m_value;
    assign o_m_axis_tuser = r_m_status;

`ifndef SYNTHESIS
    a_res_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> !r_res_valid)
        else $error("result slot overwritten");
    a_fpu_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fpu_done |-> (r_state == ST_FPU))
        else $error("fp unit finished outside an inner step");
    a_inner_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FPU) |-> (r_k < w_inner_a))
        else $error("inner index beyond inner dimension");
    a_no_accept_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_o_we && (r_state == ST_OWRITE)) |-> !o_s_axis_tready)
        else $error("command accepted during compute");
`endif

endmodule

// File: tb/sv/matrix_multiply_transpose_test.sv
// Self-checking testbench for the fp32 matrix multiply-accumulate block with transposes.
module matrix_multiply_transpose_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mmt_pkg::*;

    localparam logic [2:0]  OP_SPARE_5 = 3'd5;
    localparam logic [2:0]  OP_SPARE_6 = 3'd6;
    localparam logic [2:0]  OP_SPARE_7 = 3'd7;
    localparam logic [31:0] NAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] NAN_QUIET   = 32'h0040_0000;
    localparam int          DEPTH       = 256;
    localparam longint      CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
    } result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;
    logic [2:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [4:0]  i_cfg_wdata = '0;

    matrix_multiply_transpose dut (.*);

    always #5 i_clk = ~i_clk;

    // Mirror of the block's state.
    logic [31:0] a_mem [DEPTH];
    logic [31:0] b_mem [DEPTH];
    logic [31:0] c_mem [DEPTH];
    bit          a_set [DEPTH];
    bit          b_set [DEPTH];
    bit          c_set [DEPTH];
    logic [4:0]  cfg_reg [7];

    result_t pending_results[$];
    result_t got_result;
    int      errors = 0;
    int      items_sent = 0;
    longint  cycles = 0;
    bit      idle_on = 1'b1;

    // ---------------- single-precision arithmetic ----------------

    function automatic bit is_nan(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic bit is_inf(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] == 0;
    endfunction

    // Value is mant * 2**expo.
    function automatic void fp_unpack(input logic [31:0] x, output logic [63:0] mant,
                                      output int expo);
        if (x[30:23] == 0) begin
            mant = {41'd0, 1'b0, x[22:0]};
            expo = -149;
        end else begin
            mant = {41'd0, 1'b1, x[22:0]};
            expo = int'(x[30:23]) - 150;
        end
    endfunction

    // Rounds sign * m * 2**e (m nonzero) to nearest even, with subnormals and overflow.
    function automatic logic [31:0] fp_round(bit s, logic [63:0] m, int e);
        int          p;
        int          sh;
        int          be;
        logic [63:0] q;
        bit          g;
        bit          st;
        p = 63;
        while (!m[p]) p--;
        sh = p - 23;
        if (-149 - e > sh) sh = -149 - e;
        if (sh <= 0) begin
            q = m << (-sh);
            g = 0;
            st = 0;
        end else if (sh > 64) begin
            q = 0;
            g = 0;
            st = 1;
        end else begin
            q = (sh == 64) ? 64'd0 : m >> sh;
            g = m[sh-1];
            st = (sh == 1) ? 1'b0 : ((m & ((64'd1 << (sh - 1)) - 1)) != 0);
        end
        if (g && (st || q[0])) q++;
        if (q[24]) begin
            q = q >> 1;
            sh++;
        end
        be = 150 + e + sh;
        if (!q[23]) return {s, 8'd0, q[22:0]};
        if (be >= 255) return {s, 8'hFF, 23'd0};
        return {s, be[7:0], q[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        bit          s;
        logic [63:0] ma;
        logic [63:0] mb;
        int          ea;
        int          eb;
        s = a[31] ^ b[31];
        if (is_nan(a)) return a | NAN_QUIET;
        if (is_nan(b)) return b | NAN_QUIET;
        if (is_inf(a)) return (b[30:0] == 0) ? NAN_DEFAULT : {s, 8'hFF, 23'd0};
        if (is_inf(b)) return (a[30:0] == 0) ? NAN_DEFAULT : {s, 8'hFF, 23'd0};
        if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        return fp_round(s, ma * mb, ea + eb);
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        int          ea;
        int          eb;
        int          emin;
        longint      sum;
        if (is_nan(a)) return a | NAN_QUIET;
        if (is_nan(b)) return b | NAN_QUIET;
        if (is_inf(a)) return (is_inf(b) && a[31] != b[31]) ? NAN_DEFAULT : a;
        if (is_inf(b)) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 0) return b;
        if (b[30:0] == 0) return a;
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        // A far smaller operand only matters as a sticky bit well below the round point.
        if (ea - eb > 30) begin
            mb = 1;
            eb = ea - 30;
        end else if (eb - ea > 30) begin
            ma = 1;
            ea = eb - 30;
        end
        emin = (ea < eb) ? ea : eb;
        ma = ma << (ea - emin);
        mb = mb << (eb - emin);
        sum = (a[31] ? -longint'(ma) : longint'(ma)) + (b[31] ? -longint'(mb) : longint'(mb));
        if (sum == 0) return 32'd0;
        if (sum < 0) return fp_round(1'b1, 64'(-sum), emin);
        return fp_round(1'b0, 64'(sum), emin);
    endfunction

    // ---------------- block predictor ----------------

    function automatic int dim_of(logic [2:0] idx);
        return (cfg_reg[idx] > 16) ? 16 : int'(cfg_reg[idx]);
    endfunction

    function automatic int out_rows();
        return cfg_reg[CFG_TRANS_A][0] ? dim_of(CFG_A_COLS) : dim_of(CFG_A_ROWS);
    endfunction

    function automatic int out_cols();
        return cfg_reg[CFG_TRANS_B][0] ? dim_of(CFG_B_ROWS) : dim_of(CFG_B_COLS);
    endfunction

    function automatic int inner_left();
        return cfg_reg[CFG_TRANS_A][0] ? dim_of(CFG_A_ROWS) : dim_of(CFG_A_COLS);
    endfunction

    function automatic int inner_right();
        return cfg_reg[CFG_TRANS_B][0] ? dim_of(CFG_B_COLS) : dim_of(CFG_B_ROWS);
    endfunction

    // True when a compute would touch no element that was never written.
    function automatic bit compute_defined();
        if (inner_left() != inner_right()) return 1;
        for (int i = 0; i < dim_of(CFG_A_ROWS) * dim_of(CFG_A_COLS); i++)
            if (!a_set[i]) return 0;
        for (int i = 0; i < dim_of(CFG_B_ROWS) * dim_of(CFG_B_COLS); i++)
            if (!b_set[i]) return 0;
        if (!cfg_reg[CFG_CLEAR][0])
            for (int i = 0; i < out_rows() * out_cols(); i++)
                if (!c_set[i]) return 0;
        return 1;
    endfunction

    function automatic logic [1:0] gemm_update();
        int          ac;
        int          bc;
        int          orows;
        int          ocols;
        int          inner;
        int          ai;
        int          bi;
        logic [31:0] acc;
        ac = dim_of(CFG_A_COLS);
        bc = dim_of(CFG_B_COLS);
        orows = out_rows();
        ocols = out_cols();
        inner = inner_left();
        if (inner != inner_right()) return ST_MISMATCH;
        if (cfg_reg[CFG_CLEAR][0])
            for (int i = 0; i < orows * ocols; i++) begin
                c_mem[i] = 32'd0;
                c_set[i] = 1;
            end
        for (int i = 0; i < orows; i++)
            for (int j = 0; j < ocols; j++) begin
                acc = c_mem[(i * ocols + j) % DEPTH];
                for (int k = 0; k < inner; k++) begin
                    ai = cfg_reg[CFG_TRANS_A][0] ? k * ac + i : i * ac + k;
                    bi = cfg_reg[CFG_TRANS_B][0] ? j * bc + k : k * bc + j;
                    acc = fp_add(acc, fp_mul(a_mem[ai % DEPTH], b_mem[bi % DEPTH]));
                end
                c_mem[(i * ocols + j) % DEPTH] = acc;
                c_set[(i * ocols + j) % DEPTH] = 1;
            end
        return ST_OK;
    endfunction

    function automatic result_t predict_command(logic [2:0] op, logic [7:0] addr,
                                                logic [31:0] val);
        result_t r;
        r = '{status: ST_OK, value: 32'd0};
        case (op)
            OP_WR_A: begin
                if (addr < dim_of(CFG_A_ROWS) * dim_of(CFG_A_COLS)) begin
                    a_mem[addr] = val;
                    a_set[addr] = 1;
                end else r.status = ST_RANGE;
            end
            OP_WR_B: begin
                if (addr < dim_of(CFG_B_ROWS) * dim_of(CFG_B_COLS)) begin
                    b_mem[addr] = val;
                    b_set[addr] = 1;
                end else r.status = ST_RANGE;
            end
            OP_WR_OUT: begin
                if (addr < out_rows() * out_cols()) begin
                    c_mem[addr] = val;
                    c_set[addr] = 1;
                end else r.status = ST_RANGE;
            end
            OP_COMPUTE: r.status = gemm_update();
            OP_RD_OUT: begin
                if (addr < out_rows() * out_cols()) r.value = c_mem[addr];
                else r.status = ST_RANGE;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- drivers and checker ----------------

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** matrix_multiply_transpose: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: status %0d value %h",
                       o_m_axis_tuser, o_m_axis_tdata);
                errors++;
            end else begin
                got_result = pending_results.pop_front();
                if (o_m_axis_tuser !== got_result.status) begin
                    $error("status: expected %0d, got %0d", got_result.status, o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tdata !== got_result.value) begin
                    $error("read_value: expected %h, got %h", got_result.value, o_m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    // Result-side backpressure in random bursts.
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
                repeat ($urandom_range(0, 19)) @(negedge i_clk);
            end
        end
    end

    // Called and returning at a falling edge.
    task automatic send_command(input logic [2:0] op, input logic [7:0] addr,
                                input logic [31:0] val);
        if (idle_on && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        pending_results.push_back(predict_command(op, addr, val));
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = {val, addr};
        i_s_axis_tuser = op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        items_sent++;
    endtask

    task automatic wait_idle();
        wait (pending_results.size() == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [4:0] value);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = value;
        cfg_reg[idx] = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] random_fp();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: x[30:23] = 8'($urandom_range(118, 136));
            6: ;
            7: case ($urandom_range(0, 5))
                0: x = {x[31], 31'd0};
                1: x = {x[31], 8'hFF, 23'd0};
                2: x = {x[31], 8'hFF, 1'b1, x[21:0]};
                3: x = {x[31], 8'hFF, 1'b0, x[21:1], 1'b1};
                4: x = {x[31], 8'hFE, 23'h7F_FFFF};
                default: x = {x[31], 8'h00, 23'd1};
            endcase
            8: x[30:23] = 8'd0;
            default: x[30:23] = $urandom_range(0, 1) ? 8'($urandom_range(1, 12))
                                                     : 8'($urandom_range(242, 254));
        endcase
        return x;
    endfunction

    function automatic int random_dim();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return $urandom_range(17, 31);
            2: return $urandom_range(5, 16);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    function automatic logic [7:0] pick_addr(int limit, bit stray);
        if (limit < DEPTH && (limit == 0 || stray)) return 8'($urandom_range(limit, 255));
        return 8'($urandom_range(0, limit - 1));
    endfunction

    task automatic load_operands(input bit with_out);
        for (int i = 0; i < dim_of(CFG_A_ROWS) * dim_of(CFG_A_COLS); i++)
            send_command(OP_WR_A, 8'(i), random_fp());
        for (int i = 0; i < dim_of(CFG_B_ROWS) * dim_of(CFG_B_COLS); i++)
            send_command(OP_WR_B, 8'(i), random_fp());
        if (with_out)
            for (int i = 0; i < out_rows() * out_cols(); i++)
                send_command(OP_WR_OUT, 8'(i), random_fp());
    endtask

    task automatic read_some_output();
        int          limit;
        logic [7:0]  addr;
        limit = out_rows() * out_cols();
        addr = pick_addr(limit, $urandom_range(0, 9) == 0);
        if (addr < limit && !c_set[addr]) send_command(OP_WR_OUT, addr, random_fp());
        else send_command(OP_RD_OUT, addr, $urandom);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_shape();
        send_command(OP_WR_A, 8'd0, 32'h4040_0000);
        send_command(OP_WR_B, 8'd0, 32'h3F00_0000);
        send_command(OP_COMPUTE, 8'hFF, 32'hFFFF_FFFF);
        send_command(OP_RD_OUT, 8'd0, 32'd0);
        send_command(OP_WR_A, 8'd1, 32'h3F80_0000);
        send_command(OP_WR_B, 8'd255, 32'h3F80_0000);
        send_command(OP_RD_OUT, 8'd255, 32'd0);
        send_command(OP_SPARE_5, 8'd0, 32'h1234_5678);
        send_command(OP_SPARE_6, 8'hAA, 32'hFFFF_FFFF);
        send_command(OP_SPARE_7, 8'h55, 32'd0);
    endtask

    task automatic test_special_values();
        logic [31:0] av [4] = '{32'h7F7F_FFFF, 32'h0000_0001, 32'h8080_0000, 32'h3F80_0000};
        logic [31:0] bv [4] = '{32'h7F7F_FFFF, 32'h3F00_0000, 32'h0080_0000, 32'hFF80_0000};
        wait_idle();
        write_reg(CFG_A_COLS, 5'd4);
        write_reg(CFG_B_ROWS, 5'd4);
        for (int i = 0; i < 4; i++) begin
            send_command(OP_WR_A, 8'(i), av[i]);
            send_command(OP_WR_B, 8'(i), bv[i]);
        end
        send_command(OP_COMPUTE, 8'd0, 32'd0);
        send_command(OP_RD_OUT, 8'd0, 32'd0);
        // A signaling NaN in A, then infinity times zero.
        send_command(OP_WR_A, 8'd0, 32'h7FA0_0000);
        send_command(OP_COMPUTE, 8'd0, 32'd0);
        send_command(OP_RD_OUT, 8'd0, 32'd0);
        send_command(OP_WR_A, 8'd0, 32'h7F80_0000);
        send_command(OP_WR_B, 8'd0, 32'h8000_0000);
        send_command(OP_COMPUTE, 8'd0, 32'd0);
        send_command(OP_RD_OUT, 8'd0, 32'd0);
    endtask

    task automatic test_mismatch_and_empty();
        wait_idle();
        write_reg(CFG_B_ROWS, 5'd3);
        send_command(OP_COMPUTE, 8'd0, 32'd0);
        send_command(OP_RD_OUT, 8'd0, 32'd0);
        // Inner dimension zero with accumulate leaves the output as loaded.
        wait_idle();
        write_reg(CFG_A_COLS, 5'd0);
        write_reg(CFG_B_ROWS, 5'd0);
        write_reg(CFG_CLEAR, 1'b0);
        send_command(OP_WR_A, 8'd0, 32'h3F80_0000);
        send_command(OP_WR_OUT, 8'd0, 32'hC2F6_0000);
        send_command(OP_COMPUTE, 8'd0, 32'd0);
        send_command(OP_RD_OUT, 8'd0, 32'd0);
    endtask

    task automatic test_full_size();
        wait_idle();
        write_reg(CFG_A_ROWS, 5'd31);
        write_reg(CFG_A_COLS, 5'd16);
        write_reg(CFG_B_ROWS, 5'd16);
        write_reg(CFG_B_COLS, 5'd2);
        write_reg(CFG_TRANS_A, 1'b1);
        write_reg(CFG_TRANS_B, 1'b0);
        write_reg(CFG_CLEAR, 1'b1);
        load_operands(1'b0);
        send_command(OP_COMPUTE, 8'd0, 32'd0);
        send_command(OP_RD_OUT, 8'd0, 32'd0);
        send_command(OP_RD_OUT, 8'd31, 32'd0);
        send_command(OP_RD_OUT, 8'd32, 32'd0);
    endtask

    task automatic test_random_phase(input int count);
        int cost;
        int computes_left;
        int sel;
        wait_idle();
        write_reg(CFG_A_ROWS, 5'(random_dim()));
        write_reg(CFG_A_COLS, 5'(random_dim()));
        write_reg(CFG_TRANS_A, 1'($urandom));
        write_reg(CFG_TRANS_B, 1'($urandom));
        write_reg(CFG_CLEAR, 1'($urandom));
        write_reg(CFG_B_COLS, 5'(random_dim()));
        if ($urandom_range(0, 3) != 0) begin
            // Mostly matching inner dimensions so computes go through.
            if (cfg_reg[CFG_TRANS_B][0])
                cfg_reg[CFG_B_COLS] = cfg_reg[CFG_TRANS_A][0] ? cfg_reg[CFG_A_ROWS]
                                                              : cfg_reg[CFG_A_COLS];
            write_reg(CFG_B_COLS, cfg_reg[CFG_B_COLS]);
            write_reg(CFG_B_ROWS, cfg_reg[CFG_TRANS_B][0] ? 5'(random_dim())
                      : (cfg_reg[CFG_TRANS_A][0] ? cfg_reg[CFG_A_ROWS] : cfg_reg[CFG_A_COLS]));
        end else write_reg(CFG_B_ROWS, 5'(random_dim()));
        load_operands(!cfg_reg[CFG_CLEAR][0]);
        cost = out_rows() * out_cols() * (inner_left() * 10 + 4);
        computes_left = (cost == 0) ? 3 : ((40000 / cost > 3) ? 3 : 40000 / cost);
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 16)
                send_command(OP_WR_A, pick_addr(dim_of(CFG_A_ROWS) * dim_of(CFG_A_COLS),
                             $urandom_range(0, 9) == 0), random_fp());
            else if (sel < 32)
                send_command(OP_WR_B, pick_addr(dim_of(CFG_B_ROWS) * dim_of(CFG_B_COLS),
                             $urandom_range(0, 9) == 0), random_fp());
            else if (sel < 44)
                send_command(OP_WR_OUT, pick_addr(out_rows() * out_cols(),
                             $urandom_range(0, 9) == 0), random_fp());
            else if (sel < 56 && computes_left > 0 && compute_defined()) begin
                send_command(OP_COMPUTE, 8'($urandom), $urandom);
                computes_left--;
            end else if (sel >= 95)
                send_command(3'($urandom_range(5, 7)), 8'($urandom), $urandom);
            else read_some_output();
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            a_set[i] = 0;
            b_set[i] = 0;
            c_set[i] = 0;
            a_mem[i] = '0;
            b_mem[i] = '0;
            c_mem[i] = '0;
        end
        cfg_reg = '{5'd1, 5'd1, 5'd1, 5'd1, 5'd0, 5'd0, 5'd1};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_shape();
        test_special_values();
        test_mismatch_and_empty();
        test_full_size();
        while (items_sent < 1400) test_random_phase($urandom_range(20, 60));
        wait_idle();
        idle_on = 1'b0;
        test_random_phase(120);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("** matrix_multiply_transpose: PASSED **");
        else
            $display("** matrix_multiply_transpose: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mmt_pkg.sv
rtl/core/mmt_fpu.sv
rtl/core/matrix_multiply_transpose.sv
tb/sv/matrix_multiply_transpose_test.sv
